### sv/u8sf_pkg.sv
package u8sf_pkg;

    // default depth of the queue of finished runs between front and back
    localparam int RUN_FIFO_DEPTH = 4;

    // byte class masks and tags
    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] MASK_CONT = 8'hC0;
    localparam logic [7:0] TAG_CONT  = 8'h80;
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] TAG_LEAD2  = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] TAG_LEAD3  = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] TAG_LEAD4  = 8'hF0;

    // continuation bytes still missing after a lead
    localparam logic [1:0] NEED_TWO_BYTE   = 2'd1;
    localparam logic [1:0] NEED_THREE_BYTE = 2'd2;
    localparam logic [1:0] NEED_FOUR_BYTE  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       message_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       message_end;
    } out_beat_t;

    // one complete run of bytes caused by one input beat
    typedef struct packed {
        logic [3:0][7:0] run_bytes;
        logic [1:0]      last_idx;
        logic            msg_end;
    } run_t;

endpackage

### sv/u8sf_front.sv
module u8sf_front
    import u8sf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     beat_valid,
    input  in_beat_t beat_data,
    input  logic     space,
    output logic     beat_ready,
    output logic     run_push,
    output run_t     run_data
);

    logic [1:0]      need_reg;
    logic [1:0]      need_next;
    logic [1:0]      held_reg;
    logic [1:0]      held_next;
    logic [2:0][7:0] held_bytes_reg;

    logic       take;
    logic [7:0] b;
    logic       is_cont;
    logic       consumed;
    logic       emit;
    logic       hold_wr;
    logic [1:0] hold_idx;

    assign beat_ready = space;
    assign take       = beat_valid && space;
    assign b          = beat_data.data_byte;
    assign is_cont    = (b & MASK_CONT) == TAG_CONT;
    assign consumed   = (need_reg != 2'd0) && is_cont;
    assign run_push   = take && emit;

    // classify the byte and work out the pending sequence
    always_comb
    begin
        emit      = 1'b0;
        hold_wr   = 1'b0;
        hold_idx  = held_reg;
        need_next = need_reg;
        held_next = held_reg;
        run_data.run_bytes = {b, b, b, b};
        run_data.last_idx  = 2'd0;
        run_data.msg_end   = beat_data.message_last;
        if (consumed)
        begin
            if (need_reg == NEED_TWO_BYTE)
            begin
                // sequence complete: held bytes then this one
                emit = 1'b1;
                run_data.run_bytes[0] = held_bytes_reg[0];
                run_data.run_bytes[1] = (held_reg == 2'd1) ? b : held_bytes_reg[1];
                run_data.run_bytes[2] = (held_reg == 2'd2) ? b : held_bytes_reg[2];
                run_data.run_bytes[3] = b;
                run_data.last_idx     = held_reg;
                need_next = 2'd0;
                held_next = 2'd0;
            end
            else
            begin
                hold_wr   = 1'b1;
                held_next = held_reg + 2'd1;
                need_next = need_reg - 2'd1;
            end
        end
        else
        begin
            // fresh byte, any broken sequence is dropped
            need_next = 2'd0;
            held_next = 2'd0;
            hold_idx  = 2'd0;
            if (b <= ASCII_MAX)
            begin
                emit = 1'b1;
            end
            else if ((b & MASK_LEAD2) == TAG_LEAD2)
            begin
                hold_wr = 1'b1; held_next = 2'd1; need_next = NEED_TWO_BYTE;
            end
            else if ((b & MASK_LEAD3) == TAG_LEAD3)
            begin
                hold_wr = 1'b1; held_next = 2'd1; need_next = NEED_THREE_BYTE;
            end
            else if ((b & MASK_LEAD4) == TAG_LEAD4)
            begin
                hold_wr = 1'b1; held_next = 2'd1; need_next = NEED_FOUR_BYTE;
            end
        end
        // end of message drops whatever is still pending
        if (beat_data.message_last)
        begin
            need_next = 2'd0;
            held_next = 2'd0;
        end
    end

    // sequence counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_reg <= 2'd0;
            held_reg <= 2'd0;
        end
        else if (take)
        begin
            need_reg <= need_next;
            held_reg <= held_next;
        end
    end

    // held bytes of the pending sequence
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (take && hold_wr && hold_idx == 2'(i))
            begin
                held_bytes_reg[i] <= b;
            end
        end
    end

endmodule

### sv/u8sf_fifo.sv
module u8sf_fifo
    import u8sf_pkg::*;
#(
    parameter int Depth = RUN_FIFO_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  run_t push_data,
    output logic space,
    input  logic pop,
    output logic valid,
    output run_t head
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    run_t            entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign space = count_reg != CntW'(Depth);
    assign valid = count_reg != '0;
    assign head  = entry_reg[rd_ptr_reg];

    // pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    // run storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/u8sf_back.sv
module u8sf_back
    import u8sf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      run_valid,
    input  run_t      run_data,
    output logic      run_pop,
    output logic      beat_valid,
    input  logic      beat_ready,
    output out_beat_t beat_data
);

    run_t       cur_reg;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       active_reg;
    logic       at_last;

    assign at_last  = idx_reg == cur_reg.last_idx;
    assign idx_next = idx_reg + 2'd1;
    assign run_pop  = run_valid && (!active_reg || (beat_ready && at_last));

    // current byte of the run
    assign beat_valid            = active_reg;
    assign beat_data.out_byte    = cur_reg.run_bytes[idx_reg];
    assign beat_data.run_last    = at_last;
    assign beat_data.message_end = at_last && cur_reg.msg_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= 2'd0;
        end
        else if (run_pop)
        begin
            active_reg <= 1'b1;
            idx_reg    <= 2'd0;
        end
        else if (active_reg && beat_ready)
        begin
            if (at_last)
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_pop)
        begin
            cur_reg <= run_data;
        end
    end

endmodule

### sv/utf8_sequence_filter_core.sv
// the first byte of a run (an ascii byte, or the lead of a completed sequence) is written into
// the run queue when the input beat that releases it is taken, then loaded into the emitter's
// run register and presented from there; the rest of the run follows one byte per cycle while out_ready is high
// throughput: one input byte per cycle while the run queue has space, and one output byte per
// cycle while out_ready is high, set by the run queue between the classifier and the byte emitter
// reset: rst_n async active low, clears pending sequence, queue and output
module utf8_sequence_filter_core
    import u8sf_pkg::*;
#(
    parameter int RunFifoDepth = RUN_FIFO_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    logic run_push;
    run_t run_in;
    logic fifo_space;
    logic fifo_valid;
    logic run_pop;
    run_t run_head;

    // classifier and sequence holder
    u8sf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (in_valid),
        .beat_data  (in_data),
        .space      (fifo_space),
        .beat_ready (in_ready),
        .run_push   (run_push),
        .run_data   (run_in)
    );

    // queue of complete runs
    u8sf_fifo #(
        .Depth (RunFifoDepth)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (run_push),
        .push_data (run_in),
        .space     (fifo_space),
        .pop       (run_pop),
        .valid     (fifo_valid),
        .head      (run_head)
    );

    // byte emitter
    u8sf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .run_valid  (fifo_valid),
        .run_data   (run_head),
        .run_pop    (run_pop),
        .beat_valid (out_valid),
        .beat_ready (out_ready),
        .beat_data  (out_data)
    );

    // no run is pushed into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) run_push |-> fifo_space)
        else $error("run pushed into full queue");

    // an accepted ascii byte always yields a run
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !in_data.data_byte[7]) |-> run_push)
        else $error("ascii byte not forwarded");

    // message end only on the last byte of a run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.message_end) |-> out_data.run_last)
        else $error("message end outside run end");

    // a waiting run is taken as soon as the emitter is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_valid && !out_valid) |-> run_pop)
        else $error("emitter idle with run waiting");

endmodule

### sim/utf8_sequence_filter_core_tb.sv
module utf8_sequence_filter_core_tb
    import u8sf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BEATS = 400;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 20;

    // one pending input beat, optionally held back until all output has drained
    typedef struct {
        in_beat_t beat;
        bit       wait_drain;
    } stim_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_beat_t out_data;

    stim_t     stim_q[$];
    out_beat_t expected_bytes[$];

    // software copy of the sanitizer state
    logic [7:0] seq_hold [3];
    logic [1:0] seq_need;
    logic [1:0] seq_count;

    logic in_taken;
    int   total_beats;
    int   beats_in;
    int   beats_out;
    int   msg_ends;
    int   errors;
    int   burst_left;
    int   gap_left;
    int   stall_left;
    int   stall_mode;

    utf8_sequence_filter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // queue one raw byte for the driver
    task automatic add_byte(input logic [7:0] b, input logic last, input bit drain = 1'b0);
        stim_t s;
        s.beat.data_byte    = b;
        s.beat.message_last = last;
        s.wait_drain        = drain;
        stim_q = {stim_q, s};
    endtask

    // lead byte of a sequence of the given length, random payload bits
    function automatic logic [7:0] lead_byte(input int len);
        logic [7:0] b;
        case (len)
            2:       b = TAG_LEAD2 | 8'($urandom_range(0, 31));
            3:       b = TAG_LEAD3 | 8'($urandom_range(0, 15));
            default: b = TAG_LEAD4 | 8'($urandom_range(0, 7));
        endcase
        return b;
    endfunction

    function automatic logic [7:0] cont_byte();
        return TAG_CONT | 8'($urandom_range(0, 63));
    endfunction

    // expected output run for one accepted input beat
    task automatic filter_byte(input in_beat_t beat);
        logic [7:0] b;
        logic [7:0] run[$];
        out_beat_t  ob;
        bit         taken;
        int         i;
        b     = beat.data_byte;
        taken = 1'b0;

        // pending sequence: extend, complete or break it
        if (seq_need != 2'd0)
        begin
            if ((b & MASK_CONT) == TAG_CONT)
            begin
                taken = 1'b1;
                if (seq_need == NEED_TWO_BYTE)
                begin
                    for (i = 0; i < seq_count; i++)
                        run = {run, seq_hold[i]};
                    run = {run, b};
                    seq_need  = 2'd0;
                    seq_count = 2'd0;
                end
                else
                begin
                    seq_hold[seq_count] = b;
                    seq_count = seq_count + 2'd1;
                    seq_need  = seq_need - 2'd1;
                end
            end
            else
            begin
                seq_need  = 2'd0;
                seq_count = 2'd0;
            end
        end

        // fresh byte: ascii passes, leads start a sequence, the rest is dropped
        if (!taken)
        begin
            if (b <= ASCII_MAX)
            begin
                run = {run, b};
            end
            else if ((b & MASK_LEAD2) == TAG_LEAD2)
            begin
                seq_hold[0] = b; seq_count = 2'd1; seq_need = NEED_TWO_BYTE;
            end
            else if ((b & MASK_LEAD3) == TAG_LEAD3)
            begin
                seq_hold[0] = b; seq_count = 2'd1; seq_need = NEED_THREE_BYTE;
            end
            else if ((b & MASK_LEAD4) == TAG_LEAD4)
            begin
                seq_hold[0] = b; seq_count = 2'd1; seq_need = NEED_FOUR_BYTE;
            end
        end

        // end of message drops whatever is still incomplete
        if (beat.message_last)
        begin
            seq_need  = 2'd0;
            seq_count = 2'd0;
        end

        for (i = 0; i < run.size(); i++)
        begin
            ob.out_byte    = run[i];
            ob.run_last    = (i == run.size() - 1);
            ob.message_end = (i == run.size() - 1) && beat.message_last;
            expected_bytes = {expected_bytes, ob};
        end
    endtask

    task automatic report_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // input driver: bursts with random gaps, optional drain pause
    always @(negedge clk)
    begin
        logic     next_valid;
        in_beat_t next_data;
        next_valid = in_valid;
        next_data  = in_data;
        if (!rst_n)
        begin
            next_valid = 1'b0;
        end
        else if (!(in_valid && !in_taken))
        begin
            next_valid = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (stim_q.size() > 0 &&
                     !(stim_q[0].wait_drain && expected_bytes.size() > 0))
            begin
                next_data  = stim_q[0].beat;
                next_valid = 1'b1;
                void'(stim_q.pop_front());
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        in_valid <= next_valid;
        in_data  <= next_data;
    end

    // output stall pattern: picks a new random mode whenever its stall counter runs out
    always @(negedge clk)
    begin
        if (stall_left <= 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // monitor: check output beats, then predict from accepted input beats
    always @(posedge clk)
    begin
        out_beat_t exp_beat;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                beats_out++;
                if (out_data.message_end)
                    msg_ends++;
                if (expected_bytes.size() == 0)
                begin
                    report_error($sformatf("unexpected output beat byte=%02h last=%b end=%b",
                        out_data.out_byte, out_data.run_last, out_data.message_end));
                end
                else
                begin
                    exp_beat = expected_bytes.pop_front();
                    if (out_data !== exp_beat)
                        report_error($sformatf({"output beat %0d: exp byte=%02h last=%b end=%b,",
                            " got byte=%02h last=%b end=%b"},
                            beats_out, exp_beat.out_byte, exp_beat.run_last,
                            exp_beat.message_end, out_data.out_byte, out_data.run_last,
                            out_data.message_end));
                end
            end
            if (in_valid && in_ready)
            begin
                beats_in++;
                filter_byte(in_data);
            end
            in_taken <= in_valid && in_ready;
        end
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("timeout with %0d of %0d input beats accepted, %0d output beats pending",
            beats_in, total_beats, expected_bytes.size());
        $display("*** FAILED ***");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        int tokens;
        int pick;
        int len;
        int keep;
        int t;
        int k;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_ready  = 1'b0;
        in_taken   = 1'b0;
        seq_hold   = '{default: 8'h00};
        seq_need   = 2'd0;
        seq_count  = 2'd0;
        beats_in   = 0;
        beats_out  = 0;
        msg_ends   = 0;
        errors     = 0;
        burst_left = 8;
        gap_left   = 0;
        stall_left = 0;
        stall_mode = 0;

        // directed: ascii extremes, each sequence length, drops and breaks
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b1);
        add_byte(8'hC2, 1'b0);
        add_byte(8'hA9, 1'b0);
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b0);
        add_byte(8'hAC, 1'b0);
        add_byte(8'hF0, 1'b0);
        add_byte(8'h9F, 1'b0);
        add_byte(8'h98, 1'b0);
        add_byte(8'h80, 1'b1);
        // stray continuations and invalid leads
        add_byte(8'h80, 1'b0, 1'b1);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hF8, 1'b0);
        add_byte(8'hFF, 1'b0);
        // broken by ascii, then broken by a new lead
        add_byte(8'hC3, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'hE2, 1'b0);
        add_byte(8'hC3, 1'b0);
        add_byte(8'hBF, 1'b0);
        // cut short by end of message, then a break on the last byte
        add_byte(8'hF4, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h80, 1'b1);
        add_byte(8'hDF, 1'b0);
        add_byte(8'h3F, 1'b1);

        // random messages, mostly well-formed with some noise and truncation
        k = stim_q.size();
        while (stim_q.size() < k + RANDOM_BEATS)
        begin
            tokens = $urandom_range(1, 10);
            for (t = 0; t < tokens; t++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    add_byte(8'($urandom_range(0, 127)), 1'b0);
                end
                else if (pick < 82)
                begin
                    len = $urandom_range(2, 4);
                    add_byte(lead_byte(len), 1'b0);
                    for (int i = 1; i < len; i++)
                        add_byte(cont_byte(), 1'b0);
                end
                else if (pick < 92)
                begin
                    len  = $urandom_range(2, 4);
                    keep = $urandom_range(0, len - 2);
                    add_byte(lead_byte(len), 1'b0);
                    for (int i = 0; i < keep; i++)
                        add_byte(cont_byte(), 1'b0);
                end
                else
                begin
                    add_byte(8'($urandom_range(0, 255)), 1'b0);
                end
            end
            stim_q[$].beat.message_last = 1'b1;
        end
        // pause the sender until the output has drained, twice in the random part
        stim_q[k].wait_drain = 1'b1;
        stim_q[k + RANDOM_BEATS / 2].wait_drain = 1'b1;
        total_beats = stim_q.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all input accepted and every predicted beat seen
        while (beats_in < total_beats || expected_bytes.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d input beats and %0d checked output beats,",
            beats_in, beats_out);
        $display("including %0d message ends, with %0d errors", msg_ends, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
